// ----- design/fltm_pkg.sv -----
package fltm_pkg;

   localparam int FLTM_COUNT_BITS = 16;

   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 48;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   localparam int SPEED_W = 22;
   localparam logic [SPEED_W-1:0] SPEED_MAX = 22'h3F_FFFF;

   localparam logic [7:0]  MAX_LEVEL    = 8'd5;
   localparam logic [7:0]  MAX_PERCENT  = 8'd100;
   localparam logic [15:0] PERCENT_STEP = 16'd400;

   localparam logic [15:0] DUTY_STEP    = 16'd8000;
   localparam logic [15:0] DUTY_LEVEL4  = 16'd30000;
   localparam logic [15:0] DUTY_LEVEL5  = 16'd36000;

   localparam logic [15:0] OFFSET_LEVEL3 = 16'd13000;
   localparam logic [15:0] OFFSET_LEVEL4 = 16'd15400;
   localparam logic [15:0] OFFSET_LEVEL5 = 16'd17500;

   localparam logic [15:0] WINDOW_RESET  = 16'd500;
   localparam logic [7:0]  RETRY_RESET   = 8'd10;
   localparam logic [15:0] MIN_RPM_RESET = 16'd4000;
   localparam logic [15:0] STALL_RESET   = 16'd1000;

   typedef enum logic [2:0] {
      MODE_SET_LEVEL = 3'd0,
      MODE_TACH      = 3'd1,
      MODE_TICK      = 3'd2,
      MODE_START     = 3'd3,
      MODE_PERCENT   = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      REG_WINDOW  = 2'd0,
      REG_RETRY   = 2'd1,
      REG_MIN_RPM = 2'd2,
      REG_STALL   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [15:0] window_ticks;
      logic [7:0]  retry_limit;
      logic [15:0] min_rpm_adjust;
      logic [15:0] stall_rpm_per_level;
   } cfg_type;

   function automatic logic [15:0] level_duty(input logic [2:0] lvl);
      logic [15:0] duty;
      case (lvl)
         3'd4:    duty = DUTY_LEVEL4;
         3'd5:    duty = DUTY_LEVEL5;
         default: duty = 16'({13'b0, lvl} * DUTY_STEP);
      endcase
      return duty;
   endfunction

endpackage

// ----- design/fltm_csr.sv -----
module fltm_csr import fltm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   logic          wr_en;
   reg_index_type sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign sel        = reg_index_type'(csr_paddr[3:2]);
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ticks        <= WINDOW_RESET;
         cfg_ff.retry_limit         <= RETRY_RESET;
         cfg_ff.min_rpm_adjust      <= MIN_RPM_RESET;
         cfg_ff.stall_rpm_per_level <= STALL_RESET;
      end else if (wr_en) begin
         case (sel)
            REG_WINDOW:  cfg_ff.window_ticks        <= csr_pwdata[15:0];
            REG_RETRY:   cfg_ff.retry_limit         <= csr_pwdata[7:0];
            REG_MIN_RPM: cfg_ff.min_rpm_adjust      <= csr_pwdata[15:0];
            REG_STALL:   cfg_ff.stall_rpm_per_level <= csr_pwdata[15:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_WINDOW:  csr_prdata = {16'b0, cfg_ff.window_ticks};
         REG_RETRY:   csr_prdata = {24'b0, cfg_ff.retry_limit};
         REG_MIN_RPM: csr_prdata = {16'b0, cfg_ff.min_rpm_adjust};
         REG_STALL:   csr_prdata = {16'b0, cfg_ff.stall_rpm_per_level};
         default:     csr_prdata = '0;
      endcase
   end

endmodule

// ----- design/fan_level_tach_monitor.sv -----
// Channel   Dir  Fields (low bit first)
// req_*     in   tuser: mode[2:0]; tdata: value[7:0]
// rsp_*     out  tdata: duty_ns[15:0] pwm_on[16] current_level[19:17]
//                speed_rpm[41:20] rpm_done[42] reset_request[43] bad_value[44]
// csr_*     in   APB write/read, registers at 0x0, 0x4, 0x8, 0xC
//
// One request per clock while rsp_tready keeps up: a request waits in the input
// register, and the fan state and the result register update together when the
// result slot is free or being drained. rsp_tvalid rises once the request moves
// on from the input register. Synchronous active-high reset clears fan state and
// loads register defaults. A stalled rsp side holds its data; req_tready drops
// only once both stages are full and rsp_tready is low.
module fan_level_tach_monitor import fltm_pkg::*; #(
   parameter int COUNT_BITS = FLTM_COUNT_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // value[7:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // mode[2:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // duty, pwm_on, level, speed, done, req, bad
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int SW = (COUNT_BITS + 7 > SPEED_W) ? COUNT_BITS + 7 : SPEED_W;

   cfg_type cfg;

   fltm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   logic                   in_valid_ff;
   logic [2:0]             mode_ff;
   logic [7:0]             value_ff;
   logic                   out_valid_ff;
   logic [RSP_TDATA_W-1:0] out_data_ff;
   logic                   advance;

   logic [2:0]            level_ff,  level_in;
   logic [15:0]           duty_ff,   duty_in;
   logic                  meas_ff,   meas_in;
   logic [COUNT_BITS-1:0] pulse_ff,  pulse_in;
   logic [15:0]           left_ff,   left_in;
   logic [7:0]            retry_ff,  retry_in;

   logic [SPEED_W-1:0] speed;
   logic               done;
   logic               rreq;
   logic               bad;

   logic [SW-1:0]      cnt_ext, raw_rpm, adj_rpm, best_rpm;
   logic [15:0]        offset;
   logic               adj_use;
   logic [SPEED_W-1:0] fin_speed;
   logic [18:0]        stall_lim;
   logic               stalled;
   logic [15:0]        left_dec;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         mode_ff  <= req_tuser;
         value_ff <= req_tdata;
      end
   end

   // speed at window end: count * 40 as shift-add, level offset, clamp
   always_comb begin
      cnt_ext = SW'(pulse_ff);
      raw_rpm = (cnt_ext << 5) + (cnt_ext << 3);
      case (level_ff)
         3'd3:    offset = OFFSET_LEVEL3;
         3'd4:    offset = OFFSET_LEVEL4;
         3'd5:    offset = OFFSET_LEVEL5;
         default: offset = 16'd0;
      endcase
      adj_rpm  = SW'(offset) + cnt_ext;
      adj_use  = (offset != 16'd0) && (raw_rpm > SW'(cfg.min_rpm_adjust)) &&
                 (adj_rpm > raw_rpm);
      best_rpm = adj_use ? adj_rpm : raw_rpm;
      fin_speed = (best_rpm > SW'(SPEED_MAX)) ? SPEED_MAX : best_rpm[SPEED_W-1:0];
   end

   assign stall_lim = {16'b0, level_ff} * {3'b0, cfg.stall_rpm_per_level};
   assign stalled   = (level_ff != 3'd0) && !(fin_speed > {3'b0, stall_lim});
   assign left_dec  = (left_ff != 16'd0) ? left_ff - 16'd1 : 16'd0;

   always_comb begin
      level_in = level_ff;
      duty_in  = duty_ff;
      meas_in  = meas_ff;
      pulse_in = pulse_ff;
      left_in  = left_ff;
      retry_in = retry_ff;
      speed    = '0;
      done     = 1'b0;
      rreq     = 1'b0;
      bad      = 1'b0;
      case (mode_type'(mode_ff))
         MODE_SET_LEVEL: begin
            if (value_ff > MAX_LEVEL) begin
               bad = 1'b1;
            end else if (value_ff[2:0] != level_ff) begin
               level_in = value_ff[2:0];
               duty_in  = level_duty(value_ff[2:0]);
            end
         end
         MODE_TACH: begin
            if (meas_ff && (pulse_ff != '1)) begin
               pulse_in = pulse_ff + COUNT_BITS'(1);
            end
         end
         MODE_TICK: begin
            if (meas_ff) begin
               left_in = left_dec;
               if (left_dec == 16'd0) begin
                  meas_in = 1'b0;
                  speed   = fin_speed;
                  done    = 1'b1;
                  if (!stalled) begin
                     retry_in = 8'd0;
                  end else if (retry_ff <= cfg.retry_limit) begin
                     rreq    = 1'b1;
                     duty_in = level_duty(level_ff);
                     if (retry_ff != 8'hFF) begin
                        retry_in = retry_ff + 8'd1;
                     end
                  end
               end
            end
         end
         MODE_START: begin
            if (level_ff == 3'd0) begin
               meas_in = 1'b0;
               left_in = 16'd0;
               done    = 1'b1;
            end else begin
               meas_in  = 1'b1;
               pulse_in = '0;
               left_in  = (cfg.window_ticks == 16'd0) ? 16'd1 : cfg.window_ticks;
            end
         end
         MODE_PERCENT: begin
            if (value_ff > MAX_PERCENT) begin
               bad = 1'b1;
            end else begin
               duty_in = {8'b0, value_ff} * PERCENT_STEP;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         duty_ff  <= '0;
         meas_ff  <= 1'b0;
         pulse_ff <= '0;
         left_ff  <= '0;
         retry_ff <= '0;
      end else if (advance) begin
         level_ff <= level_in;
         duty_ff  <= duty_in;
         meas_ff  <= meas_in;
         pulse_ff <= pulse_in;
         left_ff  <= left_in;
         retry_ff <= retry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= {3'b0, bad, rreq, done, speed, level_in,
                         (duty_in != 16'd0), duty_in};
      end
   end

endmodule

// ----- design/fltm_checker.sv -----
module fltm_checker import fltm_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // speed only shows on a finished measurement
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[42] |-> rsp_tdata[41:20] == 22'd0)
      else $error("speed without rpm_done");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[16] == (rsp_tdata[15:0] != 16'd0))
      else $error("pwm_on disagrees with duty");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[19:17] <= 3'd5 && rsp_tdata[15:0] <= 16'd40000)
      else $error("level or duty out of range");

   // a rejected value never comes with a measurement or power-cycle request
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[44] |-> !rsp_tdata[43] && !rsp_tdata[42])
      else $error("bad_value with measurement result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind fan_level_tach_monitor fltm_checker u_fltm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
